[sv/tvse_pkg.sv]
// Package for the typed value serial encoder.
// Holds the channel item types, the command codes and the lead byte codes.
// No dependencies.
package tvse_pkg;

  localparam int unsigned MaxBytes = 9;

  typedef enum logic [2:0] {
    CMD_NULL    = 3'd0,
    CMD_BOOL    = 3'd1,
    CMD_INT32   = 3'd2,
    CMD_INT64   = 3'd3,
    CMD_DOUBLE  = 3'd4,
    CMD_MILLIS  = 3'd5,
    CMD_MINUTES = 3'd6,
    CMD_UNUSED  = 3'd7
  } cmd_t;

  // Lead bytes and compact bases.
  localparam logic [7:0] LEAD_NULL      = 8'h4e;
  localparam logic [7:0] LEAD_TRUE      = 8'h54;
  localparam logic [7:0] LEAD_FALSE     = 8'h46;
  localparam logic [7:0] BASE_INT_1     = 8'h90;
  localparam logic [7:0] BASE_INT_2     = 8'hc8;
  localparam logic [7:0] BASE_INT_3     = 8'hd4;
  localparam logic [7:0] LEAD_INT       = 8'h49;
  localparam logic [7:0] BASE_LONG_1    = 8'he0;
  localparam logic [7:0] BASE_LONG_2    = 8'hf8;
  localparam logic [7:0] BASE_LONG_3    = 8'h3c;
  localparam logic [7:0] LEAD_LONG_32   = 8'h59;
  localparam logic [7:0] LEAD_LONG      = 8'h4c;
  localparam logic [7:0] LEAD_DBL_ZERO  = 8'h5b;
  localparam logic [7:0] LEAD_DBL_ONE   = 8'h5c;
  localparam logic [7:0] LEAD_DBL_BYTE  = 8'h5d;
  localparam logic [7:0] LEAD_DBL_SHORT = 8'h5e;
  localparam logic [7:0] LEAD_DBL       = 8'h44;
  localparam logic [7:0] LEAD_MILLIS    = 8'h4a;
  localparam logic [7:0] LEAD_MINUTES   = 8'h4b;

  localparam logic [63:0] DBL_ONE_BITS  = 64'h3ff0000000000000;
  localparam logic [10:0] DBL_EXP_BIAS  = 11'd1023;
  localparam logic [10:0] DBL_EXP_MAX   = 11'd1038;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // Encoded form of one value: byte 0 goes out first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
  } enc_t;

endpackage

[sv/tvse_encode.sv]
// Combinational encoder: one typed value in, up to nine serialized bytes out.
// Depends on tvse_pkg.
module tvse_encode (
  input  tvse_pkg::in_item_t item,
  output tvse_pkg::enc_t     enc
);

  logic [63:0]        u;
  logic signed [31:0] v32;
  logic signed [63:0] v64;
  logic               neg;
  logic [10:0]        dexp;
  logic [51:0]        mant;
  logic [3:0]         e;
  logic [15:0]        hi;
  logic [15:0]        hi_shl;
  logic               integral;
  logic [16:0]        mag;
  logic [15:0]        w16;
  logic               fits8;
  logic               fits16;

  always_comb begin
    u    = item.value;
    v32  = $signed(u[31:0]);
    v64  = $signed(u);
    neg  = u[63];
    dexp = u[62:52];
    mant = u[51:0];
    e    = 4'(dexp - tvse_pkg::DBL_EXP_BIAS);
    hi   = mant[51:36];
    // Fraction bits of an exponent-in-range double sit below bit 52-e of the mantissa.
    hi_shl   = hi << e;
    integral = (dexp >= tvse_pkg::DBL_EXP_BIAS) && (dexp <= tvse_pkg::DBL_EXP_MAX) &&
               (hi_shl == 16'd0) && (mant[35:0] == 36'd0);
    mag    = 17'({1'b1, hi} >> (5'd16 - {1'b0, e}));
    w16    = neg ? 16'(17'd0 - mag) : mag[15:0];
    fits8  = neg ? (mag <= 17'd128) : (mag <= 17'd127);
    fits16 = neg ? (mag <= 17'd32768) : (mag <= 17'd32767);
  end

  always_comb begin
    enc.bytes = '0;
    enc.len   = 4'd0;
    case (tvse_pkg::cmd_t'(item.cmd))
      tvse_pkg::CMD_NULL: begin
        enc.bytes[0] = tvse_pkg::LEAD_NULL;
        enc.len      = 4'd1;
      end
      tvse_pkg::CMD_BOOL: begin
        enc.bytes[0] = (u != 64'd0) ? tvse_pkg::LEAD_TRUE : tvse_pkg::LEAD_FALSE;
        enc.len      = 4'd1;
      end
      tvse_pkg::CMD_INT32: begin
        if (v32 >= -32'sd16 && v32 <= 32'sd47) begin
          enc.bytes[0] = u[7:0] + tvse_pkg::BASE_INT_1;
          enc.len      = 4'd1;
        end else if (v32 >= -32'sd2048 && v32 <= 32'sd2047) begin
          enc.bytes[0] = u[15:8] + tvse_pkg::BASE_INT_2;
          enc.bytes[1] = u[7:0];
          enc.len      = 4'd2;
        end else if (v32 >= -32'sd262144 && v32 <= 32'sd262143) begin
          enc.bytes[0] = u[23:16] + tvse_pkg::BASE_INT_3;
          enc.bytes[1] = u[15:8];
          enc.bytes[2] = u[7:0];
          enc.len      = 4'd3;
        end else begin
          enc.bytes[0] = tvse_pkg::LEAD_INT;
          for (int k = 0; k < 4; k++) begin
            enc.bytes[k+1] = u[8*(3-k) +: 8];
          end
          enc.len = 4'd5;
        end
      end
      tvse_pkg::CMD_INT64: begin
        if (v64 >= -64'sd8 && v64 <= 64'sd15) begin
          enc.bytes[0] = u[7:0] + tvse_pkg::BASE_LONG_1;
          enc.len      = 4'd1;
        end else if (v64 >= -64'sd2048 && v64 <= 64'sd2047) begin
          enc.bytes[0] = u[15:8] + tvse_pkg::BASE_LONG_2;
          enc.bytes[1] = u[7:0];
          enc.len      = 4'd2;
        end else if (v64 >= -64'sd262144 && v64 <= 64'sd262143) begin
          enc.bytes[0] = u[23:16] + tvse_pkg::BASE_LONG_3;
          enc.bytes[1] = u[15:8];
          enc.bytes[2] = u[7:0];
          enc.len      = 4'd3;
        end else if ((&u[63:31]) || !(|u[63:31])) begin
          enc.bytes[0] = tvse_pkg::LEAD_LONG_32;
          for (int k = 0; k < 4; k++) begin
            enc.bytes[k+1] = u[8*(3-k) +: 8];
          end
          enc.len = 4'd5;
        end else begin
          enc.bytes[0] = tvse_pkg::LEAD_LONG;
          for (int k = 0; k < 8; k++) begin
            enc.bytes[k+1] = u[8*(7-k) +: 8];
          end
          enc.len = 4'd9;
        end
      end
      tvse_pkg::CMD_DOUBLE: begin
        if (u[62:0] == 63'd0) begin
          enc.bytes[0] = tvse_pkg::LEAD_DBL_ZERO;
          enc.len      = 4'd1;
        end else if (u == tvse_pkg::DBL_ONE_BITS) begin
          enc.bytes[0] = tvse_pkg::LEAD_DBL_ONE;
          enc.len      = 4'd1;
        end else if (integral && fits8) begin
          enc.bytes[0] = tvse_pkg::LEAD_DBL_BYTE;
          enc.bytes[1] = w16[7:0];
          enc.len      = 4'd2;
        end else if (integral && fits16) begin
          enc.bytes[0] = tvse_pkg::LEAD_DBL_SHORT;
          enc.bytes[1] = w16[15:8];
          enc.bytes[2] = w16[7:0];
          enc.len      = 4'd3;
        end else begin
          enc.bytes[0] = tvse_pkg::LEAD_DBL;
          for (int k = 0; k < 8; k++) begin
            enc.bytes[k+1] = u[8*(7-k) +: 8];
          end
          enc.len = 4'd9;
        end
      end
      tvse_pkg::CMD_MILLIS: begin
        enc.bytes[0] = tvse_pkg::LEAD_MILLIS;
        for (int k = 0; k < 8; k++) begin
          enc.bytes[k+1] = u[8*(7-k) +: 8];
        end
        enc.len = 4'd9;
      end
      tvse_pkg::CMD_MINUTES: begin
        enc.bytes[0] = tvse_pkg::LEAD_MINUTES;
        for (int k = 0; k < 4; k++) begin
          enc.bytes[k+1] = u[8*(3-k) +: 8];
        end
        enc.len = 4'd5;
      end
      default: begin
        // The unused command produces no bytes.
        enc.len = 4'd0;
      end
    endcase
  end

endmodule

[sv/tvse_serialize.sv]
// Byte serializer: holds one encoded value and shifts it into the output register.
// Depends on tvse_pkg.
module tvse_serialize (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enc_valid,
  input  tvse_pkg::enc_t      enc,
  output logic                load,
  output logic                out_valid,
  input  logic                out_stall,
  output tvse_pkg::out_item_t out_data
);

  logic [tvse_pkg::MaxBytes-1:0][7:0] buf_r, buf_nxt;
  logic [3:0]                         cnt_r, cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  tvse_pkg::out_item_t                out_data_r, out_data_nxt;
  logic                               emit;

  always_comb begin
    emit = (cnt_r != 4'd0) && (!out_valid_r || !out_stall);
    // A new value loads when the buffer is empty or its last byte leaves now.
    load = enc_valid && ((cnt_r == 4'd0) || ((cnt_r == 4'd1) && emit));

    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      out_data_nxt.out_byte  = buf_r[0];
      out_data_nxt.last_byte = (cnt_r == 4'd1);
    end

    if (load) begin
      buf_nxt = enc.bytes;
      cnt_nxt = enc.len;
    end else if (emit) begin
      buf_nxt = {8'd0, buf_r[tvse_pkg::MaxBytes-1:1]};
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/typed_value_serial_encoder.sv]
// Top level of the typed value serial encoder: input register, encoder, serializer.
// Depends on tvse_pkg, tvse_encode and tvse_serialize.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) takes one item per cycle
// while in_stall is low: a type command and a 64-bit operand. The result
// channel (out_valid, out_stall, out_data) delivers the serialized encoding
// one byte per item, in order, with last_byte set on the final byte of each
// value. An accepted item is held in the input register, encoded and loaded
// into the byte buffer when the buffer is free, and its first byte then moves
// into the output register. While out_stall is low, the output register moves
// one byte per cycle; a value's encoding has 1 to 9 bytes. The next value loads
// in the same cycle that the previous value's last byte leaves the buffer, so
// bytes flow without gaps. An item with the unused command produces no bytes
// but still passes through the byte buffer, which leaves a gap in the output.
// Reset clears the valid flags and the byte count; no item is in flight after it.
// When the receiver stalls, the output register holds its byte, the buffer
// holds, and the input register fills and then raises in_stall.
module typed_value_serial_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tvse_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tvse_pkg::out_item_t out_data
);

  logic               a_valid_r, a_valid_nxt;
  tvse_pkg::in_item_t a_item_r, a_item_nxt;
  tvse_pkg::enc_t     enc;
  logic               load;

  always_comb begin
    in_stall    = a_valid_r && !load;
    a_valid_nxt = in_stall ? a_valid_r : in_valid;
    a_item_nxt  = (in_valid && !in_stall) ? in_data : a_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= a_item_nxt;
  end

  tvse_encode u_encode (
    .item (a_item_r),
    .enc  (enc)
  );

  tvse_serialize u_serialize (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc_valid (a_valid_r),
    .enc       (enc),
    .load      (load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // No encoding is longer than the buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> (enc.len <= 4'(tvse_pkg::MaxBytes)))
    else $error("encoded length exceeds buffer depth");

  // Every defined command produces at least one byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && (a_item_r.cmd != tvse_pkg::CMD_UNUSED)) |-> (enc.len != 4'd0))
    else $error("defined command encoded to no bytes");

  // Once a non-final byte is taken, the next byte of the value follows at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_byte) |=> out_valid)
    else $error("gap inside a value's encoding");
`endif

endmodule
